// ===== design/fmb_pkg.sv =====
// Shared constants, types and codes for the framed multichannel biquad.
package fmb_pkg;

	// Sizing
	localparam int CHANNELS   = 4;
	localparam int COEF_WIDTH = 32;
	localparam int NCOEF      = 5;
	localparam int SAMPLE_W   = 24;
	localparam int HDR_W      = 8;
	localparam int IN_COEF_W  = 32;
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CIDX_W     = 3;

	// Fixed-point formats: stored coefficient is Q4.FRAC_W
	localparam int FRAC_W    = COEF_WIDTH - 4;
	localparam int PROD_W    = COEF_WIDTH + SAMPLE_W;
	localparam int SUM_W     = PROD_W + 3;
	localparam int COEF_DROP = (COEF_WIDTH <= IN_COEF_W) ? IN_COEF_W - COEF_WIDTH : 0;
	localparam int COEF_PAD  = (COEF_WIDTH > IN_COEF_W) ? COEF_WIDTH - IN_COEF_W : 0;

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Frame headers: channel n uses HDR_CH0 + n * 16
	localparam logic [HDR_W-1:0] HDR_CH0 = 8'h8F;

	// Saturation bounds
	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef enum logic {
		CMD_AUDIO,
		CMD_COEF
	} cmd_kind_t;

	typedef enum logic [CIDX_W-1:0] {
		COEF_B0 = 3'd0,
		COEF_B1 = 3'd1,
		COEF_B2 = 3'd2,
		COEF_A1 = 3'd3,
		COEF_A2 = 3'd4
	} coef_idx_t;

	typedef struct packed {
		cmd_kind_t                     kind;
		logic [CH_W-1:0]               ch;
		coef_idx_t                     idx;
		logic signed [SAMPLE_W-1:0]    smp;
		logic signed [COEF_WIDTH-1:0]  coef;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_beat_t;

endpackage

// ===== design/fmb_front.sv =====
// Front end: classifies accepted beats and turns them into queue commands.
module fmb_front (
	input  logic                                   accept,
	input  logic                                   op,
	input  logic [fmb_pkg::HDR_W-1:0]              frame_header,
	input  logic signed [fmb_pkg::SAMPLE_W-1:0]    sample,
	input  logic [1:0]                             coef_channel,
	input  logic [fmb_pkg::CIDX_W-1:0]             coef_index,
	input  logic signed [fmb_pkg::IN_COEF_W-1:0]   coef_value,
	output fmb_pkg::cmd_beat_t                     push
);

	logic [fmb_pkg::HDR_W-1:0]                 hdr_diff;
	logic                                      hdr_ok;
	logic                                      coef_ok;
	logic signed [2*fmb_pkg::IN_COEF_W-1:0]    coef_ext;
	logic signed [2*fmb_pkg::IN_COEF_W-1:0]    coef_scaled;

	// Decode header: low nibble must match, upper channel bits must be in range
	always_comb begin
		hdr_diff = 8'(frame_header - fmb_pkg::HDR_CH0);
		hdr_ok   = (hdr_diff[3:0] == 4'h0) && (hdr_diff[7:6] == 2'b00) &&
		           ({1'b0, hdr_diff[5:4]} < 3'(fmb_pkg::CHANNELS));
		coef_ok  = ({1'b0, coef_channel} < 3'(fmb_pkg::CHANNELS)) &&
		           (coef_index < 3'(fmb_pkg::NCOEF));
	end

	// Rescale Q4.28 input to the stored coefficient width
	always_comb begin
		coef_ext    = {{fmb_pkg::IN_COEF_W{coef_value[fmb_pkg::IN_COEF_W-1]}}, coef_value};
		coef_scaled = (coef_ext >>> fmb_pkg::COEF_DROP) <<< fmb_pkg::COEF_PAD;
	end

	// Build command; drop unknown headers and out-of-range writes
	always_comb begin
		push.valid    = accept && (op ? coef_ok : hdr_ok);
		push.cmd.kind = op ? fmb_pkg::CMD_COEF : fmb_pkg::CMD_AUDIO;
		push.cmd.ch   = op ? coef_channel[fmb_pkg::CH_W-1:0]
		                   : hdr_diff[4 +: fmb_pkg::CH_W];
		push.cmd.idx  = fmb_pkg::coef_idx_t'(coef_index);
		push.cmd.smp  = sample;
		push.cmd.coef = coef_scaled[fmb_pkg::COEF_WIDTH-1:0];
	end

endmodule

// ===== design/fmb_queue.sv =====
// Short command FIFO that decouples the front end from the filter back end.
module fmb_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  fmb_pkg::cmd_beat_t push,
	input  logic               pop,
	output fmb_pkg::cmd_beat_t head,
	output logic               full
);

	fmb_pkg::cmd_t                    mem_q [fmb_pkg::QDEPTH];
	logic [fmb_pkg::QPTR_W-1:0]       wr_q;
	logic [fmb_pkg::QPTR_W-1:0]       rd_q;
	logic [fmb_pkg::QCNT_W-1:0]       cnt_q;

	assign full       = (cnt_q == fmb_pkg::QCNT_W'(fmb_pkg::QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = mem_q[rd_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= (wr_q == fmb_pkg::QPTR_W'(fmb_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == fmb_pkg::QPTR_W'(fmb_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push.valid && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Hold entry payload
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.cmd;
		end
	end

endmodule

// ===== design/fmb_back.sv =====
// Back end: coefficient store, channel histories, multiply and accumulate stages.
module fmb_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fmb_pkg::cmd_beat_t                   head,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [fmb_pkg::HDR_W-1:0]            out_header,
	output logic signed [fmb_pkg::SAMPLE_W-1:0]  out_sample
);

	localparam int CW = fmb_pkg::COEF_WIDTH;
	localparam int SW = fmb_pkg::SAMPLE_W;
	localparam int PW = fmb_pkg::PROD_W;
	localparam int UW = fmb_pkg::SUM_W;
	localparam int FW = fmb_pkg::FRAC_W;

	// Coefficients and histories
	logic signed [CW-1:0] coef_q [fmb_pkg::CHANNELS][fmb_pkg::NCOEF];
	logic signed [SW-1:0] xh1_q  [fmb_pkg::CHANNELS];
	logic signed [SW-1:0] xh2_q  [fmb_pkg::CHANNELS];
	logic signed [SW-1:0] yh1_q  [fmb_pkg::CHANNELS];
	logic signed [SW-1:0] yh2_q  [fmb_pkg::CHANNELS];

	// Product stage
	logic                       s1_valid_q;
	logic [fmb_pkg::CH_W-1:0]   s1_ch_q;
	logic signed [SW-1:0]       s1_x_q;
	logic signed [PW-1:0]       s1_p_q [fmb_pkg::NCOEF];

	// Output register
	logic                       out_valid_q;
	logic [fmb_pkg::HDR_W-1:0]  out_header_q;
	logic signed [SW-1:0]       out_sample_q;

	logic                       is_audio;
	logic                       is_coef;
	logic                       hazard;
	logic                       adv2;
	logic                       s1_free;
	logic                       take_audio;
	logic [fmb_pkg::CH_W-1:0]   hch;
	logic signed [UW-1:0]       acc;
	logic signed [UW-1:0]       quot;
	logic                       inexact;
	logic signed [UW-1:0]       qt;
	logic signed [SW-1:0]       ysat;

	assign out_valid  = out_valid_q;
	assign out_header = out_header_q;
	assign out_sample = out_sample_q;

	// Issue control: stall an audio command while its channel is still in flight or the multiply stage cannot drain
	always_comb begin
		hch        = head.cmd.ch;
		is_audio   = head.valid && (head.cmd.kind == fmb_pkg::CMD_AUDIO);
		is_coef    = head.valid && (head.cmd.kind == fmb_pkg::CMD_COEF);
		hazard     = s1_valid_q && (s1_ch_q == hch);
		adv2       = s1_valid_q && (!out_valid_q || out_ready);
		s1_free    = !s1_valid_q || adv2;
		take_audio = is_audio && s1_free && !hazard;
		pop        = take_audio || is_coef;
	end

	// Accumulate, truncate toward zero, saturate
	always_comb begin
		acc = UW'(s1_p_q[0]) + UW'(s1_p_q[1]) + UW'(s1_p_q[2])
		    - UW'(s1_p_q[3]) - UW'(s1_p_q[4]);
		quot    = acc >>> FW;
		inexact = |acc[FW-1:0];
		qt      = quot + ((acc[UW-1] && inexact) ? UW'(1) : UW'(0));
		if (qt > UW'(fmb_pkg::SMP_MAX)) begin
			ysat = fmb_pkg::SMP_MAX;
		end else if (qt < UW'(fmb_pkg::SMP_MIN)) begin
			ysat = fmb_pkg::SMP_MIN;
		end else begin
			ysat = qt[SW-1:0];
		end
	end

	// Coefficient writes and history updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < fmb_pkg::CHANNELS; c++) begin
				for (int k = 0; k < fmb_pkg::NCOEF; k++) begin
					coef_q[c][k] <= '0;
				end
				xh1_q[c] <= '0;
				xh2_q[c] <= '0;
				yh1_q[c] <= '0;
				yh2_q[c] <= '0;
			end
		end else begin
			if (is_coef) begin
				coef_q[hch][head.cmd.idx] <= head.cmd.coef;
			end
			if (adv2) begin
				xh2_q[s1_ch_q] <= xh1_q[s1_ch_q];
				xh1_q[s1_ch_q] <= s1_x_q;
				yh2_q[s1_ch_q] <= yh1_q[s1_ch_q];
				yh1_q[s1_ch_q] <= ysat;
			end
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_valid_q <= take_audio;
			end
			if (adv2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Multiply stage payload
	always_ff @(posedge clk) begin
		if (take_audio) begin
			s1_ch_q   <= hch;
			s1_x_q    <= head.cmd.smp;
			s1_p_q[0] <= coef_q[hch][fmb_pkg::COEF_B0] * head.cmd.smp;
			s1_p_q[1] <= coef_q[hch][fmb_pkg::COEF_B1] * xh1_q[hch];
			s1_p_q[2] <= coef_q[hch][fmb_pkg::COEF_B2] * xh2_q[hch];
			s1_p_q[3] <= coef_q[hch][fmb_pkg::COEF_A1] * yh1_q[hch];
			s1_p_q[4] <= coef_q[hch][fmb_pkg::COEF_A2] * yh2_q[hch];
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (adv2) begin
			out_header_q <= 8'(fmb_pkg::HDR_CH0 + (8'(s1_ch_q) << 4));
			out_sample_q <= ysat;
		end
	end

endmodule

// ===== design/framed_multichannel_biquad.sv =====
// Accepted audio beats pass through the queue, the multiply stage register and the
// output register. Throughput: one beat per cycle across different channels while
// the output is ready; a same-channel beat waits until the previous one leaves the
// multiply stage, set by the y history feedback through multiply and accumulate.
// Reset (arst_n low) clears coefficients, histories, the queue and all valids.
module framed_multichannel_biquad (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic [fmb_pkg::HDR_W-1:0]            frame_header,
	input  logic signed [fmb_pkg::SAMPLE_W-1:0]  sample,
	input  logic [1:0]                           coef_channel,
	input  logic [fmb_pkg::CIDX_W-1:0]           coef_index,
	input  logic signed [fmb_pkg::IN_COEF_W-1:0] coef_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [fmb_pkg::HDR_W-1:0]            out_header,
	output logic signed [fmb_pkg::SAMPLE_W-1:0]  out_sample
);

	fmb_pkg::cmd_beat_t push;
	fmb_pkg::cmd_beat_t head;
	logic               pop;
	logic               full;

	assign in_ready = !full;

	fmb_front u_front (
		.accept       (in_valid && in_ready),
		.op           (op),
		.frame_header (frame_header),
		.sample       (sample),
		.coef_channel (coef_channel),
		.coef_index   (coef_index),
		.coef_value   (coef_value),
		.push         (push)
	);

	fmb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (full)
	);

	fmb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_header (out_header),
		.out_sample (out_sample)
	);

endmodule
